@@ rtl/core/air_quality_led_ring_pattern_assert.svh @@
// Assertion macros for the LED ring pattern generator, clocked on clk and reset by arst_n.
`ifndef AIR_QUALITY_LED_RING_PATTERN_ASSERT_SVH
`define AIR_QUALITY_LED_RING_PATTERN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AQLR_ASSERT_HOLDS(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aqlr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define AQLR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aqlr: next-cycle check failed");

`endif

@@ rtl/core/aqlr_pkg.sv @@
// Shared types, constants and tables of the LED ring pattern generator.
package aqlr_pkg;

	localparam int MODE_W      = 2;
	localparam int DUST_W      = 12;
	localparam int PERIOD_W    = 8;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 12;
	localparam int LED_W       = 3;
	localparam int COLOR_W     = 8;
	localparam int LIT_W       = 3;

	localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_HAZARD_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FLASH_PERIOD     = 2'd1;

	localparam logic [DUST_W-1:0]   HAZARD_THRESHOLD_RST = 12'd300;
	localparam logic [PERIOD_W-1:0] FLASH_PERIOD_RST     = 8'd20;

	localparam int BREATH_STEPS_DEF = 64;

	// Breathing angle in 1/1024 turns.
	localparam int ANGLE_W    = 10;
	localparam int ANGLE_TURN = 1024;

	// Q14 sine magnitude and brightness mapping.
	localparam int SINE_W         = 15;
	localparam int SINE_ROM_DEPTH = 256;
	localparam logic [SINE_W-1:0] SINE_ONE = 15'd16384;
	localparam logic [15:0] SINE_OFFSET    = 16'd16384;
	localparam logic [12:0] BRIGHT_SCALE   = 13'd7782;
	localparam logic [13:0] BRIGHT_FLOOR   = 14'd819;
	localparam logic [COLOR_W-1:0] BREATH_RED   = 8'd255;
	localparam logic [COLOR_W-1:0] BREATH_GREEN = 8'd180;

	localparam logic [LED_W-1:0] LAST_PIXEL = 3'd7;

	localparam int BAR_EDGES = 6;
	localparam logic [DUST_W-1:0] BAR_EDGE [BAR_EDGES] = '{
		12'd35, 12'd70, 12'd110, 12'd150, 12'd225, 12'd300
	};

	typedef struct packed {
		logic [COLOR_W-1:0] r;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] b;
	} rgb_t;

	localparam rgb_t RGB_BLACK = '{r: 8'd0, g: 8'd0, b: 8'd0};

	// Bar colour for a given number of lit pixels.
	function automatic rgb_t bar_color(input logic [LIT_W-1:0] lit);
		rgb_t c;
		case (lit) inside
			3'd1, 3'd2: c = '{r: 8'd0,   g: 8'd200, b: 8'd0};
			3'd3, 3'd4: c = '{r: 8'd200, g: 8'd200, b: 8'd0};
			3'd5, 3'd6: c = '{r: 8'd255, g: 8'd100, b: 8'd0};
			3'd7:       c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
			default:    c = RGB_BLACK;
		endcase
		return c;
	endfunction

	typedef logic [SINE_ROM_DEPTH-1:0][SINE_W-1:0] sine_rom_t;

	// Quarter-wave sine magnitude for |d| = 0..255 in 1/256 of a quarter turn.
	// Evaluated once at elaboration with a truncating Q14 polynomial.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		int z;
		int z2;
		int inner;
		int mid;
		int s;
		for (int m = 0; m < SINE_ROM_DEPTH; m++) begin
			z     = m * 64;
			z2    = (z * z) >>> 14;
			inner = 10583 - ((1302 * z2) >>> 14);
			mid   = 25736 - ((z2 * inner) >>> 14);
			s     = (z * mid) >>> 14;
			if (s > 16384) begin
				s = 16384;
			end
			rom[m] = SINE_W'(s);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

@@ rtl/core/aqlr_if.sv @@
// Valid/ready channel interfaces: refresh ticks, pixel results and register writes.
interface aqlr_in_if;
	logic                           valid;
	logic                           ready;
	logic [aqlr_pkg::MODE_W-1:0]    mode;
	logic [aqlr_pkg::DUST_W-1:0]    dust_level;

	modport source (output valid, output mode, output dust_level, input ready);
	modport sink (input valid, input mode, input dust_level, output ready);
endinterface

interface aqlr_pix_if;
	logic                           valid;
	logic                           ready;
	logic [aqlr_pkg::LED_W-1:0]     led_index;
	logic [aqlr_pkg::COLOR_W-1:0]   red;
	logic [aqlr_pkg::COLOR_W-1:0]   green;
	logic [aqlr_pkg::COLOR_W-1:0]   blue;
	logic                           last_pixel;

	modport source (output valid, output led_index, output red, output green, output blue,
		output last_pixel, input ready);
	modport sink (input valid, input led_index, input red, input green, input blue,
		input last_pixel, output ready);
endinterface

interface aqlr_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [aqlr_pkg::CFG_INDEX_W-1:0] index;
	logic [aqlr_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/air_quality_led_ring_pattern.sv @@
// Air-quality LED ring pattern generator: one refresh tick in, eight pixel colors out.
//
//  channel | dir | payload                                   | transfer when
//  tick    | in  | mode, dust_level                          | tick.valid & tick.ready
//  pixel   | out | led_index, red, green, blue, last_pixel   | pixel.valid & pixel.ready
//  cfg     | in  | index, data                               | cfg.valid & cfg.ready
//
// Each tick yields eight pixel transfers, one per cycle while pixel.ready holds, and the
// eight-pixel frame serializer sets the sustained tick rate. Before its first pixel is offered,
// a tick is registered in stage 1, goes through the brightness multiply into stage 2, and is
// then loaded into the frame buffer.
// Two stages ahead of the frame buffer let new ticks be taken while a frame drains.
// Reset clears the breathing and flash phases and loads the register reset values.
// A stalled pixel holds; cfg is always ready.
module air_quality_led_ring_pattern #(
	parameter int BREATH_STEPS = aqlr_pkg::BREATH_STEPS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	aqlr_in_if.sink    tick,
	aqlr_pix_if.source pixel,
	aqlr_cfg_if.sink   cfg
);
	import aqlr_pkg::*;

	localparam int PHASE_W  = $clog2(BREATH_STEPS);
	localparam int ANG_STEP = ANGLE_TURN / BREATH_STEPS;
	localparam int ANG_REM  = ANGLE_TURN % BREATH_STEPS;

	// Configuration and running state.
	logic [DUST_W-1:0]   hazard_thr_q;
	logic [PERIOD_W-1:0] flash_period_q;
	logic [PHASE_W-1:0]  breath_phase_q;
	logic [ANGLE_W-1:0]  ang_q;
	logic [PHASE_W-1:0]  ang_rem_q;
	logic [PERIOD_W-1:0] flash_phase_q;

	// Pipeline and frame registers.
	logic                v_s1, v_s2;
	logic [MODE_W-1:0]   mode_s1, mode_s2;
	logic [15:0]         sp_s1;
	logic [13:0]         bq_s2;
	logic [LIT_W-1:0]    lit_s1, lit_s2, lit_q;
	logic                show_s1, show_s2, show_q;
	logic                frame_v_q;
	logic [LED_W-1:0]    cnt_q;
	rgb_t                p0_q, bar_q;

	logic tick_acc, pix_acc, pix_done, frame_free, load_f, adv_s2;

	assign pix_acc    = frame_v_q && pixel.ready;
	assign pix_done   = pix_acc && (cnt_q == LAST_PIXEL);
	assign frame_free = !frame_v_q || pix_done;
	assign load_f     = v_s2 && frame_free;
	assign adv_s2     = v_s1 && (!v_s2 || load_f);
	assign tick.ready = !v_s1 || adv_s2;
	assign tick_acc   = tick.valid && tick.ready;
	assign cfg.ready  = 1'b1;

	// Fold the angle onto a quarter wave and look up the sine magnitude.
	logic [8:0]        mag_idx;
	logic              sine_neg;
	logic [SINE_W-1:0] sine_mag;
	logic [15:0]       sp_next;

	always_comb begin
		if (ang_q < 10'd256) begin
			mag_idx  = ang_q[8:0];
			sine_neg = 1'b0;
		end else if (ang_q <= 10'd512) begin
			mag_idx  = 9'(10'd512 - ang_q);
			sine_neg = 1'b0;
		end else if (ang_q < 10'd768) begin
			mag_idx  = 9'(ang_q - 10'd512);
			sine_neg = 1'b1;
		end else begin
			mag_idx  = 9'(11'd1024 - {1'b0, ang_q});
			sine_neg = 1'b1;
		end
		sine_mag = mag_idx[8] ? SINE_ONE : SINE_ROM[mag_idx[7:0]];
		sp_next  = sine_neg ? (SINE_OFFSET - 16'(sine_mag)) : (SINE_OFFSET + 16'(sine_mag));
	end

	// Bar length, hazard and flash window.
	logic [LIT_W-1:0] lit_next;
	logic             hazard, blink_on;

	always_comb begin
		lit_next = 3'd1;
		for (int k = 0; k < BAR_EDGES; k++) begin
			if (tick.dust_level >= BAR_EDGE[k]) begin
				lit_next = LIT_W'(k + 2);
			end
		end
	end

	assign hazard   = tick.dust_level >= hazard_thr_q;
	assign blink_on = flash_phase_q < (flash_period_q >> 1);

	// Phase advances.
	logic [ANGLE_W:0]   ang_sum;
	logic [PHASE_W:0]   rem_sum;
	logic [ANGLE_W-1:0] ang_next;
	logic [PHASE_W-1:0] rem_next;
	logic [PERIOD_W:0]  flash_inc;

	always_comb begin
		ang_sum = {1'b0, ang_q} + (ANGLE_W+1)'(ANG_STEP);
		rem_sum = {1'b0, ang_rem_q} + (PHASE_W+1)'(ANG_REM);
		if (rem_sum >= (PHASE_W+1)'(BREATH_STEPS)) begin
			rem_next = PHASE_W'(rem_sum - (PHASE_W+1)'(BREATH_STEPS));
			ang_next = ANGLE_W'(ang_sum + 1'b1);
		end else begin
			rem_next = PHASE_W'(rem_sum);
			ang_next = ANGLE_W'(ang_sum);
		end
		flash_inc = {1'b0, flash_phase_q} + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hazard_thr_q   <= HAZARD_THRESHOLD_RST;
			flash_period_q <= FLASH_PERIOD_RST;
			breath_phase_q <= '0;
			ang_q          <= '0;
			ang_rem_q      <= '0;
			flash_phase_q  <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_HAZARD_THRESHOLD: hazard_thr_q   <= cfg.data;
					REG_FLASH_PERIOD:     flash_period_q <= cfg.data[PERIOD_W-1:0];
					default: ;
				endcase
			end
			if (tick_acc && tick.mode == MODE_AUTO) begin
				if (breath_phase_q == PHASE_W'(BREATH_STEPS - 1)) begin
					breath_phase_q <= '0;
					ang_q          <= '0;
					ang_rem_q      <= '0;
				end else begin
					breath_phase_q <= breath_phase_q + 1'b1;
					ang_q          <= ang_next;
					ang_rem_q      <= rem_next;
				end
			end
			if (tick_acc && hazard) begin
				if (flash_inc >= {1'b0, flash_period_q}) begin
					flash_phase_q <= '0;
				end else begin
					flash_phase_q <= flash_inc[PERIOD_W-1:0];
				end
			end
		end
	end

	// Stage valids and frame control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			frame_v_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			v_s1      <= tick_acc || (v_s1 && !adv_s2);
			v_s2      <= adv_s2 || (v_s2 && !load_f);
			frame_v_q <= load_f || (frame_v_q && !pix_done);
			if (pix_acc) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Brightness in Q14 from the offset sine.
	logic [28:0] bq_prod;
	assign bq_prod = 29'(sp_s1) * 29'(BRIGHT_SCALE);

	// Pixel 0 color: from the registered brightness in auto mode, fixed red when off, fixed green in manual.
	logic [21:0] red_prod, green_prod;
	rgb_t        p0_next;

	always_comb begin
		red_prod   = 22'(bq_s2) * 22'(BREATH_RED);
		green_prod = 22'(bq_s2) * 22'(BREATH_GREEN);
		case (mode_s2)
			MODE_OFF:    p0_next = '{r: 8'd255, g: 8'd0, b: 8'd0};
			MODE_MANUAL: p0_next = '{r: 8'd0, g: 8'd255, b: 8'd0};
			MODE_AUTO:   p0_next = '{r: red_prod[21:14], g: green_prod[21:14], b: 8'd0};
			default:     p0_next = RGB_BLACK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			mode_s1 <= tick.mode;
			sp_s1   <= sp_next;
			lit_s1  <= lit_next;
			show_s1 <= !hazard || blink_on;
		end
		if (adv_s2) begin
			mode_s2 <= mode_s1;
			bq_s2   <= 14'(BRIGHT_FLOOR + 14'(bq_prod >> 14));
			lit_s2  <= lit_s1;
			show_s2 <= show_s1;
		end
		if (load_f) begin
			p0_q   <= p0_next;
			bar_q  <= bar_color(lit_s2);
			lit_q  <= lit_s2;
			show_q <= show_s2;
		end
	end

	// Serialize the frame.
	rgb_t pix_color;

	always_comb begin
		if (cnt_q == '0) begin
			pix_color = p0_q;
		end else if (show_q && cnt_q <= lit_q) begin
			pix_color = bar_q;
		end else begin
			pix_color = RGB_BLACK;
		end
	end

	assign pixel.valid      = frame_v_q;
	assign pixel.led_index  = cnt_q;
	assign pixel.red        = pix_color.r;
	assign pixel.green      = pix_color.g;
	assign pixel.blue       = pix_color.b;
	assign pixel.last_pixel = (cnt_q == LAST_PIXEL);

`include "air_quality_led_ring_pattern_assert.svh"

	// A frame never pauses between its pixels once started.
	`AQLR_ASSERT_NEXT(a_frame_gapless, pixel.valid && pixel.ready && !pixel.last_pixel, pixel.valid)
	// The breathing phase and angle move only on an auto-mode tick.
	`AQLR_ASSERT_NEXT(a_breath_hold, !(tick.valid && tick.ready && tick.mode == MODE_AUTO),
		$stable(breath_phase_q) && $stable(ang_q))
	// Phase zero always maps to angle zero with no remainder.
	`AQLR_ASSERT_HOLDS(a_angle_sync, breath_phase_q == '0, ang_q == '0 && ang_rem_q == '0)

endmodule
